FILE: hdl/stb_pkg.sv
package stb_pkg;

    localparam int MODE_W     = 3;
    localparam int ID_W       = 4;
    localparam int OUT_CNT_W  = 32;
    localparam int STATUS_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        OP_TICK    = 3'd0,
        OP_START   = 3'd1,
        OP_PAUSE   = 3'd2,
        OP_RELEASE = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        RUN_STOPPED = 2'd0,
        RUN_RUNNING = 2'd1,
        RUN_PAUSED  = 2'd2
    } run_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_READ,
        ST_MOD
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic sweep;
        logic rd_item;
        logic mod_en;
    } stb_cmd_t;

    typedef struct packed {
        logic in_tick;
        logic sweep_done;
        logic out_free;
    } stb_status_t;

endpackage

FILE: hdl/software_timer_bank_unit.sv
// Bank of NUM_TIMERS elapsed-time counters, each stopped, running or paused.
// Request channel (in_valid/in_ready): mode (0 tick, 1 start, 2 pause,
// 3 release, 4..7 read) and timer_id. Result channel (out_valid/out_ready):
// count_value and timer_status of the addressed timer after the request;
// an out-of-range timer_id reports zero for both.
// Sequence: a non-tick request is accepted, its counter is read, then it is
// updated, written back and registered as the result; the block takes no new
// request before that. A tick first walks every counter through the single
// read/write port of the counter memory, one entry per cycle, and then reads
// and reports the addressed timer the same way.
// Reset clears all counters to zero and stops every timer at once through
// per-entry valid bits; no clearing pass is needed.
// A result waits in the output register while the receiver stalls; a new
// request is still accepted, and the block holds in its final step until
// the output register is free.
module software_timer_bank_unit
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [MODE_W-1:0]    mode,
    input  logic [ID_W-1:0]      timer_id,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_CNT_W-1:0] count_value,
    output logic [STATUS_W-1:0]  timer_status
);

    stb_cmd_t    cmd;
    stb_status_t status;

    stb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    stb_datapath
    #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mode         (mode),
        .timer_id     (timer_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .count_value  (count_value),
        .timer_status (timer_status)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while previous request in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((timer_status == RUN_STOPPED) || (timer_status == RUN_RUNNING)
                       || (timer_status == RUN_PAUSED)))
        else $error("invalid timer status code on result");

    a_mod_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mod_en && !status.out_free) |=> (out_valid && cmd.mod_en))
        else $error("final step left while output register occupied");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_item, cmd.sweep, cmd.rd_item, cmd.mod_en}))
        else $error("conflicting datapath commands");
`endif

endmodule

FILE: hdl/stb_datapath.sv
module stb_datapath
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stb_cmd_t             cmd,
    output stb_status_t          status,
    input  logic [MODE_W-1:0]    mode,
    input  logic [ID_W-1:0]      timer_id,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_CNT_W-1:0] count_value,
    output logic [STATUS_W-1:0]  timer_status
);

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
    localparam int EXT_W  = IDX_W + ID_W;
    localparam int WORD_W = COUNT_WIDTH + STATUS_W;

    logic [MODE_W-1:0]      mode_reg;
    logic [ID_W-1:0]        id_reg;
    logic [CNT_W-1:0]       sweep_cnt_reg;
    logic [CNT_W-1:0]       sweep_cnt_next;
    logic [CNT_W-1:0]       sweep_prev;
    logic [WORD_W-1:0]      mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  vld_reg;
    logic [WORD_W-1:0]      rd_word_reg;
    logic                   rd_vld_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_CNT_W-1:0]   count_value_reg;
    logic [STATUS_W-1:0]    timer_status_reg;

    logic [EXT_W-1:0]       id_ext;
    logic [IDX_W-1:0]       id_idx;
    logic                   id_valid;
    logic                   sweep_done;
    logic                   sweep_rd;
    logic                   sweep_wr;
    logic                   out_free;
    logic                   mod_fire;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [WORD_W-1:0]      wr_data;
    logic [COUNT_WIDTH-1:0] old_cnt;
    run_t                   old_st;
    logic [COUNT_WIDTH-1:0] new_cnt;
    run_t                   new_st;
    logic [COUNT_WIDTH-1:0] swp_cnt;

    assign id_ext     = EXT_W'(id_reg);
    assign id_idx     = id_ext[IDX_W-1:0];
    assign id_valid   = id_ext < EXT_W'(NUM_TIMERS);
    assign sweep_done = sweep_cnt_reg == CNT_W'(NUM_TIMERS);
    assign sweep_prev = sweep_cnt_reg - CNT_W'(1);
    assign sweep_rd   = cmd.sweep && !sweep_done;
    assign sweep_wr   = cmd.sweep && (sweep_cnt_reg != '0);
    assign out_free   = !out_valid_reg || out_ready;
    assign mod_fire   = cmd.mod_en && out_free;

    assign status.in_tick    = op_t'(mode) == OP_TICK;
    assign status.sweep_done = sweep_done;
    assign status.out_free   = out_free;

    assign old_cnt = rd_vld_reg ? rd_word_reg[COUNT_WIDTH-1:0] : '0;
    assign old_st  = rd_vld_reg ? run_t'(rd_word_reg[WORD_W-1:COUNT_WIDTH]) : RUN_STOPPED;
    assign swp_cnt = (old_st == RUN_RUNNING) ? old_cnt + COUNT_WIDTH'(1) : old_cnt;

    always_comb
    begin
        new_cnt = old_cnt;
        new_st  = old_st;
        unique case (op_t'(mode_reg))
            OP_START:
            begin
                new_cnt = '0;
                new_st  = RUN_RUNNING;
            end
            OP_PAUSE:
            begin
                if (old_st == RUN_RUNNING)
                begin
                    new_st = RUN_PAUSED;
                end
            end
            OP_RELEASE:
            begin
                if (old_st == RUN_PAUSED)
                begin
                    new_st = RUN_RUNNING;
                end
            end
            default:
            begin
                new_cnt = old_cnt;
                new_st  = old_st;
            end
        endcase
    end

    assign rd_en   = sweep_rd || cmd.rd_item;
    assign rd_addr = cmd.sweep ? sweep_cnt_reg[IDX_W-1:0] : id_idx;
    assign wr_en   = sweep_wr || (mod_fire && id_valid);
    assign wr_addr = cmd.sweep ? sweep_prev[IDX_W-1:0] : id_idx;
    assign wr_data = cmd.sweep ? {old_st, swp_cnt} : {new_st, new_cnt};

    assign sweep_cnt_next = cmd.load_item ? '0
                          : (sweep_rd ? sweep_cnt_reg + CNT_W'(1) : sweep_cnt_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (mod_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= mode;
            id_reg   <= timer_id;
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
        if (mod_fire)
        begin
            count_value_reg  <= id_valid ? OUT_CNT_W'(new_cnt) : '0;
            timer_status_reg <= id_valid ? new_st : RUN_STOPPED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_cnt_reg <= sweep_cnt_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign count_value  = count_value_reg;
    assign timer_status = timer_status_reg;

endmodule

FILE: hdl/stb_ctrl.sv
module stb_ctrl
    import stb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  stb_status_t status,
    output stb_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = status.in_tick ? ST_SWEEP : ST_READ;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_item = 1'b1;
                state_next  = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.mod_en = 1'b1;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
